// ----- rtl/core/dldm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants of the doubly linked deque manager.
package dldm_pkg;

   // Field widths fixed by the request and response formats.
   localparam int ID_W               = 6;
   localparam int COUNT_W            = 7;
   localparam int NODE_COUNT_DEFAULT = 64;

   // Requested operation.
   typedef enum logic [2:0] {
      KIND_ADD_HEAD    = 3'd0,
      KIND_ADD_TAIL    = 3'd1,
      KIND_ADD_BEFORE  = 3'd2,
      KIND_ADD_AFTER   = 3'd3,
      KIND_REMOVE_HEAD = 3'd4,
      KIND_REMOVE_TAIL = 3'd5,
      KIND_REMOVE_NODE = 3'd6,
      KIND_CLEAR       = 3'd7
   } kind_type;

   // Response status.
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_EMPTY      = 2'd1,
      ST_NOT_MEMBER = 2'd2,
      ST_ALREADY    = 2'd3
   } status_type;

   // Operation actually carried out on the list once the checks pass.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_PUT_HEAD,
      OP_PUT_TAIL,
      OP_INS_BEFORE,
      OP_INS_AFTER,
      OP_TAKE_HEAD,
      OP_TAKE_TAIL,
      OP_UNLINK,
      OP_CLEAR
   } op_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_LINK,
      S_FIX
   } state_type;

   typedef struct packed {
      kind_type          kind;
      logic [ID_W-1:0]   node_id;
      logic [ID_W-1:0]   ref_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]    result_node;
      status_type         status;
      logic [COUNT_W-1:0] count_out;
   } rsp_type;

   // Membership lookups handed to the decoder.
   typedef struct packed {
      logic node_in;
      logic node_member;
      logic ref_member;
   } lookup_type;

   // Decoder verdict: what to do and whether a link read is needed first.
   typedef struct packed {
      op_type     op;
      status_type status;
      logic       need_read;
   } plan_type;

   // True when an id addresses a node of the table.
   function automatic logic id_in_table(input logic [ID_W-1:0] id, input int unsigned depth);
      return 32'(id) < depth;
   endfunction

endpackage

// ----- rtl/core/dldm_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module dldm_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/dldm_decode.sv -----
`timescale 1ns / 1ps
// Request checks and choice of the list operation for the deque manager.
module dldm_decode (
   input  dldm_pkg::req_type                 req,
   input  dldm_pkg::lookup_type              lookup,
   input  logic [dldm_pkg::ID_W-1:0]         head_id,
   input  logic [dldm_pkg::ID_W-1:0]         tail_id,
   input  logic [dldm_pkg::COUNT_W-1:0]      list_count,
   output dldm_pkg::plan_type                plan
);
   import dldm_pkg::*;

   logic empty;
   logic single;

   assign empty  = (list_count == '0);
   assign single = (list_count == COUNT_W'(1));

   // The reference is checked before the inserted node; a removal of the
   // only node needs no link read.
   always_comb begin
      plan.op        = OP_NONE;
      plan.status    = ST_OK;
      plan.need_read = 1'b0;
      unique case (req.kind)
         KIND_ADD_HEAD, KIND_ADD_TAIL: begin
            if (!lookup.node_in) begin
               plan.status = ST_NOT_MEMBER;
            end else if (lookup.node_member) begin
               plan.status = ST_ALREADY;
            end else begin
               plan.op = (req.kind == KIND_ADD_HEAD) ? OP_PUT_HEAD : OP_PUT_TAIL;
            end
         end
         KIND_ADD_BEFORE: begin
            if (!lookup.ref_member || !lookup.node_in) begin
               plan.status = ST_NOT_MEMBER;
            end else if (lookup.node_member) begin
               plan.status = ST_ALREADY;
            end else if (req.ref_id == head_id) begin
               plan.op = OP_PUT_HEAD;
            end else begin
               plan.op        = OP_INS_BEFORE;
               plan.need_read = 1'b1;
            end
         end
         KIND_ADD_AFTER: begin
            if (!lookup.ref_member || !lookup.node_in) begin
               plan.status = ST_NOT_MEMBER;
            end else if (lookup.node_member) begin
               plan.status = ST_ALREADY;
            end else if (req.ref_id == tail_id) begin
               plan.op = OP_PUT_TAIL;
            end else begin
               plan.op        = OP_INS_AFTER;
               plan.need_read = 1'b1;
            end
         end
         KIND_REMOVE_HEAD, KIND_REMOVE_TAIL: begin
            if (empty) begin
               plan.status = ST_EMPTY;
            end else begin
               plan.op = (req.kind == KIND_REMOVE_HEAD) ? OP_TAKE_HEAD : OP_TAKE_TAIL;
               plan.need_read = !single;
            end
         end
         KIND_REMOVE_NODE: begin
            if (!lookup.node_member) begin
               plan.status = ST_NOT_MEMBER;
            end else if (req.node_id == head_id) begin
               plan.op        = OP_TAKE_HEAD;
               plan.need_read = !single;
            end else if (req.node_id == tail_id) begin
               plan.op        = OP_TAKE_TAIL;
               plan.need_read = !single;
            end else begin
               plan.op        = OP_UNLINK;
               plan.need_read = 1'b1;
            end
         end
         KIND_CLEAR: begin
            plan.op = OP_CLEAR;
         end
      endcase
   end

endmodule

// ----- rtl/core/doubly_linked_deque_manager.sv -----
`timescale 1ns / 1ps
// Doubly linked deque manager: top level with sequencer, list registers and link memories.
//
// A request beat is taken when start is high and busy is low; exactly one response beat
// follows on rsp_item, marked by rsp_valid for a single cycle, and the receiver cannot
// stall it. Busy stays high from the accept until the response is issued. Head and tail
// adds, failed requests, clear and removal of the only node finish in the decode state;
// removals needing a neighbor link also pass the link state; inserts between two listed
// nodes pass decode, link and fix, as the next/prev link memories have a registered read
// port and one write port each. The link memories need no clearing pass after reset:
// membership bits are flip-flops and only links of member nodes are ever read.
module doubly_linked_deque_manager #(
   parameter int NODE_COUNT = dldm_pkg::NODE_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dldm_pkg::req_type req_item,
   output logic              rsp_valid,
   output dldm_pkg::rsp_type rsp_item
);
   import dldm_pkg::*;

   localparam int ADDR_W    = $clog2(NODE_COUNT);
   localparam int MEM_DEPTH = (NODE_COUNT < (1 << ID_W)) ? NODE_COUNT : (1 << ID_W);
   localparam int MIDX_W    = $clog2(MEM_DEPTH);

   // Id to link memory address.
   function automatic logic [ADDR_W-1:0] to_addr(input logic [ID_W-1:0] id);
      logic [ADDR_W+ID_W-1:0] wide;
      wide = {{ADDR_W{1'b0}}, id};
      return wide[ADDR_W-1:0];
   endfunction

   // Id to membership bit index.
   function automatic logic [MIDX_W-1:0] to_midx(input logic [ID_W-1:0] id);
      logic [MIDX_W+ID_W-1:0] wide;
      wide = {{MIDX_W{1'b0}}, id};
      return wide[MIDX_W-1:0];
   endfunction

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   op_type               op_ff, op_in;
   logic [ID_W-1:0]      head_ff, head_in;
   logic [ID_W-1:0]      tail_ff, tail_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [MEM_DEPTH-1:0] member_ff, member_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   lookup_type           lookup;
   plan_type             plan;

   logic                 nx_we, pv_we;
   logic [ADDR_W-1:0]    nx_waddr, pv_waddr, rd_addr;
   logic [ID_W-1:0]      nx_wdata, pv_wdata, nx_rdata, pv_rdata;
   logic [ID_W-1:0]      key_id;

   logic                 finish;
   logic [ID_W-1:0]      res_id;
   status_type           res_status;

   // Membership lookups of the held request.
   always_comb begin
      lookup.node_in     = id_in_table(req_ff.node_id, NODE_COUNT);
      lookup.node_member = lookup.node_in && member_ff[to_midx(req_ff.node_id)];
      lookup.ref_member  = id_in_table(req_ff.ref_id, NODE_COUNT)
                           && member_ff[to_midx(req_ff.ref_id)];
   end

   dldm_decode u_decode (
      .req        (req_ff),
      .lookup     (lookup),
      .head_id    (head_ff),
      .tail_id    (tail_ff),
      .list_count (count_ff),
      .plan       (plan)
   );

   // Link memories.
   dldm_ram #(.WIDTH(ID_W), .DEPTH(NODE_COUNT)) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_we),
      .wr_addr (nx_waddr),
      .wr_data (nx_wdata),
      .rd_addr (rd_addr),
      .rd_data (nx_rdata)
   );

   dldm_ram #(.WIDTH(ID_W), .DEPTH(NODE_COUNT)) u_prev_ram (
      .clock   (clock),
      .wr_en   (pv_we),
      .wr_addr (pv_waddr),
      .wr_data (pv_wdata),
      .rd_addr (rd_addr),
      .rd_data (pv_rdata)
   );

   // Node whose links are read during decode.
   always_comb begin
      priority case (plan.op)
         OP_INS_BEFORE, OP_INS_AFTER: key_id = req_ff.ref_id;
         OP_TAKE_HEAD:                key_id = head_ff;
         OP_TAKE_TAIL:                key_id = tail_ff;
         default:                     key_id = req_ff.node_id;
      endcase
   end

   assign rd_addr = to_addr(key_id);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (plan.status == ST_OK && plan.need_read) begin
               state_in = S_LINK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_LINK: begin
            if (op_ff == OP_INS_BEFORE || op_ff == OP_INS_AFTER) begin
               state_in = S_FIX;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FIX: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // List updates, link writes and response for each state.
   always_comb begin
      req_in       = req_ff;
      op_in        = op_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      member_in    = member_ff;
      nx_we        = 1'b0;
      nx_waddr     = to_addr(req_ff.node_id);
      nx_wdata     = req_ff.ref_id;
      pv_we        = 1'b0;
      pv_waddr     = to_addr(req_ff.node_id);
      pv_wdata     = req_ff.ref_id;
      finish       = 1'b0;
      res_id       = '0;
      res_status   = ST_OK;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_item;
            end
         end
         S_DECODE: begin
            op_in = plan.op;
            if (plan.status != ST_OK) begin
               finish     = 1'b1;
               res_status = plan.status;
            end else begin
               unique case (plan.op)
                  OP_PUT_HEAD: begin
                     if (count_ff == '0) begin
                        tail_in = req_ff.node_id;
                     end else begin
                        nx_we    = 1'b1;
                        nx_waddr = to_addr(req_ff.node_id);
                        nx_wdata = head_ff;
                        pv_we    = 1'b1;
                        pv_waddr = to_addr(head_ff);
                        pv_wdata = req_ff.node_id;
                     end
                     head_in                          = req_ff.node_id;
                     member_in[to_midx(req_ff.node_id)] = 1'b1;
                     count_in                         = count_ff + COUNT_W'(1);
                     finish                           = 1'b1;
                     res_id                           = req_ff.node_id;
                  end
                  OP_PUT_TAIL: begin
                     if (count_ff == '0) begin
                        head_in = req_ff.node_id;
                     end else begin
                        pv_we    = 1'b1;
                        pv_waddr = to_addr(req_ff.node_id);
                        pv_wdata = tail_ff;
                        nx_we    = 1'b1;
                        nx_waddr = to_addr(tail_ff);
                        nx_wdata = req_ff.node_id;
                     end
                     tail_in                          = req_ff.node_id;
                     member_in[to_midx(req_ff.node_id)] = 1'b1;
                     count_in                         = count_ff + COUNT_W'(1);
                     finish                           = 1'b1;
                     res_id                           = req_ff.node_id;
                  end
                  OP_TAKE_HEAD, OP_TAKE_TAIL: begin
                     // The only node leaves; longer lists wait for the link read.
                     if (!plan.need_read) begin
                        res_id = (plan.op == OP_TAKE_HEAD) ? head_ff : tail_ff;
                        member_in[to_midx(res_id)] = 1'b0;
                        head_in  = '0;
                        tail_in  = '0;
                        count_in = count_ff - COUNT_W'(1);
                        finish   = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     member_in = '0;
                     head_in   = '0;
                     tail_in   = '0;
                     count_in  = '0;
                     finish    = 1'b1;
                  end
                  OP_NONE, OP_INS_BEFORE, OP_INS_AFTER, OP_UNLINK: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LINK: begin
            unique case (op_ff)
               OP_INS_BEFORE: begin
                  // prev[ref] is the predecessor p: p -> node, node <- p.
                  nx_we    = 1'b1;
                  nx_waddr = to_addr(pv_rdata);
                  nx_wdata = req_ff.node_id;
                  pv_we    = 1'b1;
                  pv_waddr = to_addr(req_ff.node_id);
                  pv_wdata = pv_rdata;
               end
               OP_INS_AFTER: begin
                  // next[ref] is the successor q: node <- q, node -> q.
                  pv_we    = 1'b1;
                  pv_waddr = to_addr(nx_rdata);
                  pv_wdata = req_ff.node_id;
                  nx_we    = 1'b1;
                  nx_waddr = to_addr(req_ff.node_id);
                  nx_wdata = nx_rdata;
               end
               OP_TAKE_HEAD: begin
                  res_id                      = head_ff;
                  head_in                     = nx_rdata;
                  member_in[to_midx(head_ff)] = 1'b0;
                  count_in                    = count_ff - COUNT_W'(1);
                  finish                      = 1'b1;
               end
               OP_TAKE_TAIL: begin
                  res_id                      = tail_ff;
                  tail_in                     = pv_rdata;
                  member_in[to_midx(tail_ff)] = 1'b0;
                  count_in                    = count_ff - COUNT_W'(1);
                  finish                      = 1'b1;
               end
               OP_UNLINK: begin
                  // Join the two neighbors of the removed node.
                  nx_we    = 1'b1;
                  nx_waddr = to_addr(pv_rdata);
                  nx_wdata = nx_rdata;
                  pv_we    = 1'b1;
                  pv_waddr = to_addr(nx_rdata);
                  pv_wdata = pv_rdata;
                  member_in[to_midx(req_ff.node_id)] = 1'b0;
                  count_in = count_ff - COUNT_W'(1);
                  res_id   = req_ff.node_id;
                  finish   = 1'b1;
               end
               default: begin
               end
            endcase
         end
         S_FIX: begin
            // Second half of an inner insert: link node and reference together.
            nx_we = 1'b1;
            pv_we = 1'b1;
            if (op_ff == OP_INS_BEFORE) begin
               nx_waddr = to_addr(req_ff.node_id);
               nx_wdata = req_ff.ref_id;
               pv_waddr = to_addr(req_ff.ref_id);
               pv_wdata = req_ff.node_id;
            end else begin
               pv_waddr = to_addr(req_ff.node_id);
               pv_wdata = req_ff.ref_id;
               nx_waddr = to_addr(req_ff.ref_id);
               nx_wdata = req_ff.node_id;
            end
            member_in[to_midx(req_ff.node_id)] = 1'b1;
            count_in = count_ff + COUNT_W'(1);
            res_id   = req_ff.node_id;
            finish   = 1'b1;
         end
      endcase

      // Response beat carries the count after the operation.
      if (finish) begin
         rsp_valid_in       = 1'b1;
         rsp_in.result_node = res_id;
         rsp_in.status      = res_status;
         rsp_in.count_out   = count_in;
      end
   end

   // Control and list state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         member_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         member_ff    <= member_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      op_ff  <= op_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // A response beat only appears once the sequencer is back in idle.
   a_rsp_in_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_IDLE)
      else $error("response beat while the sequencer is busy");

   // The count always matches the number of member bits set.
   a_count_members: assert property (@(posedge clock) disable iff (reset)
      $countones(member_ff) == int'(count_ff))
      else $error("list count differs from membership bits");

   // An empty list keeps head and tail at zero.
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> head_ff == '0 && tail_ff == '0)
      else $error("empty list with nonzero head or tail");

   // An accepted beat is held and decoded in the next cycle.
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == S_DECODE && req_ff == $past(req_item))
      else $error("accepted request not captured for decode");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Testbench of the doubly linked deque manager: list request stimulus, prediction and response checks.
module tb;
   import dldm_pkg::*;

   localparam int TABLE_SIZE  = 64;
   localparam int TOTAL_ITEMS = 425;
   localparam int CYCLE_LIMIT = 100000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   // Requests waiting for the driver, and the responses that accepted requests owe.
   req_type requests_to_send[$];
   rsp_type expected_responses[$];

   // Predicted list state: links, membership, ends and length.
   logic [ID_W-1:0]    nxt_id[TABLE_SIZE];
   logic [ID_W-1:0]    prv_id[TABLE_SIZE];
   logic [TABLE_SIZE-1:0] in_list = '0;
   logic [ID_W-1:0]    head_node = '0;
   logic [ID_W-1:0]    tail_node = '0;
   logic [COUNT_W-1:0] length = '0;

   // Order of the list as the stimulus planner expects it, used to pick legal ids.
   logic [ID_W-1:0] planned_order[$];

   int cycle_count    = 0;
   int queued_count   = 0;
   int sent_count     = 0;
   int checked_count  = 0;
   int mismatch_count = 0;
   int peak_length    = 0;
   int status_hits[4] = '{0, 0, 0, 0};
   int hold_off       = 0;
   bit no_idle        = 1'b0;

   doubly_linked_deque_manager dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------------------------
   // Prediction of the list state, built on explicit next and prev links.
   // ---------------------------------------------------------------------------------------

   function automatic void link_at_head(input logic [ID_W-1:0] n);
      if (length == 0) begin
         tail_node = n;
      end else begin
         nxt_id[n] = head_node;
         prv_id[head_node] = n;
      end
      head_node  = n;
      in_list[n] = 1'b1;
      length     = length + 1'b1;
   endfunction

   function automatic void link_at_tail(input logic [ID_W-1:0] n);
      if (length == 0) begin
         head_node = n;
      end else begin
         prv_id[n] = tail_node;
         nxt_id[tail_node] = n;
      end
      tail_node  = n;
      in_list[n] = 1'b1;
      length     = length + 1'b1;
   endfunction

   function automatic logic [ID_W-1:0] unlink_head();
      logic [ID_W-1:0] n;
      n = head_node;
      in_list[n] = 1'b0;
      if (length == 1) begin
         head_node = '0;
         tail_node = '0;
      end else begin
         head_node = nxt_id[n];
      end
      length = length - 1'b1;
      return n;
   endfunction

   function automatic logic [ID_W-1:0] unlink_tail();
      logic [ID_W-1:0] n;
      n = tail_node;
      in_list[n] = 1'b0;
      if (length == 1) begin
         head_node = '0;
         tail_node = '0;
      end else begin
         tail_node = prv_id[n];
      end
      length = length - 1'b1;
      return n;
   endfunction

   // Applies one request to the predicted list and returns the response it should produce.
   function automatic rsp_type deque_response(input req_type r);
      rsp_type         o;
      logic [ID_W-1:0] n;
      logic [ID_W-1:0] anchor;
      logic [ID_W-1:0] p;
      logic [ID_W-1:0] q;
      o = '0;
      o.status = ST_OK;
      n = r.node_id;
      anchor = r.ref_id;
      case (r.kind)
         KIND_ADD_HEAD, KIND_ADD_TAIL: begin
            if (in_list[n]) begin
               o.status = ST_ALREADY;
            end else begin
               if (r.kind == KIND_ADD_HEAD) link_at_head(n);
               else link_at_tail(n);
               o.result_node = n;
            end
         end
         KIND_ADD_BEFORE: begin
            // The anchor is checked before the node being inserted.
            if (!in_list[anchor]) begin
               o.status = ST_NOT_MEMBER;
            end else if (in_list[n]) begin
               o.status = ST_ALREADY;
            end else begin
               if (anchor == head_node) begin
                  link_at_head(n);
               end else begin
                  p = prv_id[anchor];
                  nxt_id[p] = n;
                  prv_id[n] = p;
                  nxt_id[n] = anchor;
                  prv_id[anchor] = n;
                  in_list[n] = 1'b1;
                  length = length + 1'b1;
               end
               o.result_node = n;
            end
         end
         KIND_ADD_AFTER: begin
            if (!in_list[anchor]) begin
               o.status = ST_NOT_MEMBER;
            end else if (in_list[n]) begin
               o.status = ST_ALREADY;
            end else begin
               if (anchor == tail_node) begin
                  link_at_tail(n);
               end else begin
                  q = nxt_id[anchor];
                  prv_id[q] = n;
                  nxt_id[n] = q;
                  prv_id[n] = anchor;
                  nxt_id[anchor] = n;
                  in_list[n] = 1'b1;
                  length = length + 1'b1;
               end
               o.result_node = n;
            end
         end
         KIND_REMOVE_HEAD: begin
            if (length == 0) o.status = ST_EMPTY;
            else o.result_node = unlink_head();
         end
         KIND_REMOVE_TAIL: begin
            if (length == 0) o.status = ST_EMPTY;
            else o.result_node = unlink_tail();
         end
         KIND_REMOVE_NODE: begin
            if (!in_list[n]) begin
               o.status = ST_NOT_MEMBER;
            end else if (n == head_node) begin
               o.result_node = unlink_head();
            end else if (n == tail_node) begin
               o.result_node = unlink_tail();
            end else begin
               p = prv_id[n];
               q = nxt_id[n];
               nxt_id[p] = q;
               prv_id[q] = p;
               in_list[n] = 1'b0;
               length = length - 1'b1;
               o.result_node = n;
            end
         end
         default: begin
            in_list   = '0;
            head_node = '0;
            tail_node = '0;
            length    = '0;
         end
      endcase
      o.count_out = length;
      if (int'(length) > peak_length) peak_length = int'(length);
      return o;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus planning: tracks list order so that most requests name real members.
   // ---------------------------------------------------------------------------------------

   function automatic int index_of(input logic [ID_W-1:0] id);
      for (int i = 0; i < planned_order.size(); i++) begin
         if (planned_order[i] == id) return i;
      end
      return -1;
   endfunction

   function automatic void plan_step(input req_type r);
      int ni;
      int ai;
      ni = index_of(r.node_id);
      ai = index_of(r.ref_id);
      case (r.kind)
         KIND_ADD_HEAD:    if (ni < 0) planned_order.push_front(r.node_id);
         KIND_ADD_TAIL:    if (ni < 0) planned_order.push_back(r.node_id);
         KIND_ADD_BEFORE:  if (ai >= 0 && ni < 0) planned_order.insert(ai, r.node_id);
         KIND_ADD_AFTER:   if (ai >= 0 && ni < 0) planned_order.insert(ai + 1, r.node_id);
         KIND_REMOVE_HEAD: if (planned_order.size() != 0) void'(planned_order.pop_front());
         KIND_REMOVE_TAIL: if (planned_order.size() != 0) void'(planned_order.pop_back());
         KIND_REMOVE_NODE: if (ni >= 0) planned_order.delete(ni);
         default:          planned_order.delete();
      endcase
   endfunction

   function automatic void queue_request(input req_type r);
      requests_to_send.push_back(r);
      plan_step(r);
      queued_count++;
   endfunction

   function automatic void add_req(input kind_type k, input int n, input int anchor);
      req_type r;
      r.kind    = k;
      r.node_id = n[ID_W-1:0];
      r.ref_id  = anchor[ID_W-1:0];
      queue_request(r);
   endfunction

   function automatic logic [ID_W-1:0] random_id();
      return ID_W'($urandom_range(0, TABLE_SIZE - 1));
   endfunction

   function automatic logic [ID_W-1:0] random_member();
      if (planned_order.size() == 0) return random_id();
      return planned_order[$urandom_range(0, planned_order.size() - 1)];
   endfunction

   // Legal insert of a node that is not yet listed; only called while the table has room.
   function automatic req_type insert_request();
      req_type r;
      int      k;
      logic [ID_W-1:0] id;
      id = random_id();
      while (index_of(id) >= 0) id = id + 1'b1;
      k = $urandom_range(0, 3);
      if (planned_order.size() == 0 && k >= 2) k = k - 2;
      r.kind    = kind_type'(k[2:0]);
      r.node_id = id;
      r.ref_id  = random_member();
      return r;
   endfunction

   function automatic req_type remove_request();
      req_type r;
      r.kind    = kind_type'(3'($urandom_range(4, 6)));
      r.node_id = random_member();
      r.ref_id  = random_id();
      return r;
   endfunction

   function automatic req_type noise_request();
      req_type r;
      r.kind    = kind_type'(3'($urandom_range(0, 7)));
      r.node_id = random_id();
      r.ref_id  = random_id();
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Driver: presents queued requests with random gaps and predicts each accepted beat.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         hold_off = 0;
      end else begin
         if (start && !busy) begin
            expected_responses.push_back(deque_response(req_item));
            sent_count++;
         end
         if (start && busy) begin
            // The current request has not been taken yet; keep it on the port.
         end else if (hold_off > 0) begin
            hold_off--;
            start <= 1'b0;
         end else if (requests_to_send.size() != 0) begin
            req_item <= requests_to_send.pop_front();
            start <= 1'b1;
            // Occasionally switch between gapped traffic and back-to-back stretches.
            if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
            hold_off = no_idle ? 0 : $urandom_range(0, 11);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: every response beat is compared with the oldest prediction.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_responses.size() == 0) begin
            report_mismatch("response beat with no request outstanding");
         end else begin
            want = expected_responses.pop_front();
            checked_count++;
            status_hits[want.status]++;
            if (rsp_item.result_node !== want.result_node)
               report_mismatch($sformatf("result_node got %0d, expected %0d",
                                         rsp_item.result_node, want.result_node));
            if (rsp_item.status !== want.status)
               report_mismatch($sformatf("status got %0d, expected %0d",
                                         rsp_item.status, want.status));
            if (rsp_item.count_out !== want.count_out)
               report_mismatch($sformatf("count_out got %0d, expected %0d",
                                         rsp_item.count_out, want.count_out));
         end
      end
   end

   // Run limit in case the block stops answering.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus and end of run.
   // ---------------------------------------------------------------------------------------
   initial begin
      int target;
      int phase_left;
      int roll;
      target = 0;
      phase_left = 0;

      // Directed part: empty-list errors, single-node add and remove, every insert position.
      add_req(KIND_REMOVE_HEAD, 0, 0);
      add_req(KIND_REMOVE_TAIL, 63, 63);
      add_req(KIND_REMOVE_NODE, 0, 63);
      add_req(KIND_ADD_BEFORE, 5, 0);
      add_req(KIND_ADD_AFTER, 5, 63);
      add_req(KIND_ADD_HEAD, 0, 63);
      add_req(KIND_REMOVE_HEAD, 63, 0);
      add_req(KIND_ADD_TAIL, 63, 0);
      add_req(KIND_REMOVE_TAIL, 0, 63);
      add_req(KIND_ADD_TAIL, 63, 21);
      add_req(KIND_ADD_HEAD, 0, 42);
      add_req(KIND_ADD_HEAD, 0, 0);
      add_req(KIND_ADD_BEFORE, 21, 0);
      add_req(KIND_ADD_AFTER, 42, 63);
      add_req(KIND_ADD_BEFORE, 5, 63);
      add_req(KIND_ADD_AFTER, 10, 21);
      // Anchor equal to the inserted node, then an unknown anchor with a listed node.
      add_req(KIND_ADD_BEFORE, 5, 5);
      add_req(KIND_ADD_AFTER, 5, 7);
      add_req(KIND_REMOVE_NODE, 0, 42);
      add_req(KIND_REMOVE_NODE, 21, 21);
      add_req(KIND_REMOVE_NODE, 42, 0);
      add_req(KIND_REMOVE_NODE, 33, 5);
      add_req(KIND_REMOVE_HEAD, 42, 42);
      add_req(KIND_REMOVE_TAIL, 21, 21);
      add_req(KIND_CLEAR, 42, 21);
      add_req(KIND_CLEAR, 63, 63);
      add_req(KIND_ADD_HEAD, 5, 0);

      // Fill the whole table through random legal inserts, then wander between length targets.
      while (planned_order.size() < TABLE_SIZE) queue_request(insert_request());
      while (queued_count < TOTAL_ITEMS) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 60);
            case ($urandom_range(0, 3))
               0:       target = 0;
               1:       target = TABLE_SIZE;
               default: target = $urandom_range(1, TABLE_SIZE - 1);
            endcase
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            queue_request(noise_request());
         end else if (roll < 14) begin
            add_req(KIND_CLEAR, random_id(), random_id());
         end else if (planned_order.size() < TABLE_SIZE &&
                      (planned_order.size() < target ||
                       (planned_order.size() == target && $urandom_range(0, 1) == 1))) begin
            queue_request(insert_request());
         end else begin
            queue_request(remove_request());
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last request to be taken and answered, then let the block idle before the final check.
      while (requests_to_send.size() != 0 || start || expected_responses.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (expected_responses.size() != 0)
         report_mismatch("responses still outstanding at end of run");

      $display("run: %0d requests sent, %0d responses checked, longest list %0d nodes",
               sent_count, checked_count, peak_length);
      $display("run: status ok %0d, list empty %0d, not member %0d, already member %0d",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- doubly_linked_deque_manager.f -----
rtl/core/dldm_pkg.sv
rtl/core/dldm_ram.sv
rtl/core/dldm_decode.sv
rtl/core/doubly_linked_deque_manager.sv
tb/tb.sv
